FILE: rtl/bpa_pkg.sv
// Shared types and constants for the buddy page allocator.
// Depends on nothing; imported by bpa_buddy, buddy_page_allocator and the testbench.
package bpa_pkg;

  // Fixed field widths of the external interface.
  localparam int IDX_W  = 12;
  localparam int REQ_W  = 4;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;
  localparam int PCNT_W = 13;
  localparam int BASE_W = 40;
  localparam int CFG_W  = 40;

  // Stored order field, working order counter (holds ORDERS itself) and free count.
  localparam int ORD_W = 4;
  localparam int OQ_W  = 5;
  localparam int CNT_W = 13;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NOMEM   = 2'd1,
    STAT_NOTUSED = 2'd2,
    STAT_RANGE   = 2'd3
  } status_e;

  typedef enum logic {
    REG_PAGE_COUNT = 1'b0,
    REG_BASE_PAGE  = 1'b1
  } reg_e;

  // Per-page bookkeeping word.
  typedef struct packed {
    logic             used;
    logic [ORD_W-1:0] order;
  } meta_t;

  typedef enum logic [4:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_INIT_FREE,
    ST_F_RD,
    ST_F_CHK,
    ST_F_RM,
    ST_F_LOOP,
    ST_F_BUD,
    ST_F_BMETA,
    ST_F_MRG1,
    ST_F_MRG2,
    ST_F_FIN,
    ST_A_SCAN,
    ST_A_LOOP,
    ST_A_BUD,
    ST_PUSH1,
    ST_PUSH2,
    ST_RM_RD,
    ST_RM_WR,
    ST_DONE
  } state_e;

endpackage

FILE: rtl/bpa_buddy.sv
// Buddy locator: absolute page number XOR block size, mapped back into the pool.
// Depends on bpa_pkg. Result is valid the cycle after load_i.
module bpa_buddy #(
  parameter int PAGES = 4096
) (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  logic [$clog2(PAGES)-1:0]      page_i,
  input  logic [bpa_pkg::ORD_W-1:0]     order_i,
  input  logic [bpa_pkg::BASE_W-1:0]    pool_base_i,
  input  logic [$clog2(PAGES+1)-1:0]    pool_pages_i,
  output logic                          exists_o,
  output logic [$clog2(PAGES)-1:0]      buddy_o
);
  import bpa_pkg::*;

  localparam int IW = $clog2(PAGES);
  localparam int AW = BASE_W + 1;
  localparam int DW = AW + 1;

  logic [AW-1:0] abs_q;
  logic [DW-1:0] diff;

  // First stage: absolute buddy page number.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      abs_q <= (AW'(pool_base_i) + AW'(page_i)) ^ (AW'(1) << order_i);
    end
  end

  // Second stage: offset back into the pool; a borrow means below the pool start.
  assign diff     = {1'b0, abs_q} - DW'(pool_base_i);
  assign exists_o = !diff[DW-1] && (diff[AW-1:0] < AW'(pool_pages_i));
  assign buddy_o  = diff[IW-1:0];

endmodule

FILE: rtl/buddy_page_allocator.sv
// Buddy page allocator. One transaction at a time; per-page state lives in three
// single-port-read memories (used/order, next link, prev link). After reset a
// clearing pass over every page runs before the first transaction is taken.
// Allocate scans the orders upward and then splits one level at a time; free
// merges with the buddy one order at a time; init runs a sweep over every page
// plus one free per pool page. Each list removal waits on the registered read
// of the link memories.
// Depends on bpa_pkg and bpa_buddy.
module buddy_page_allocator #(
  parameter int PAGES  = 4096,
  parameter int ORDERS = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [bpa_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [bpa_pkg::OP_W-1:0]    op_i,
  input  logic [bpa_pkg::REQ_W-1:0]   req_order_i,
  input  logic [bpa_pkg::IDX_W-1:0]   page_index_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bpa_pkg::IDX_W-1:0]   block_page_o,
  output logic [bpa_pkg::STAT_W-1:0]  status_o
);
  import bpa_pkg::*;

  localparam int IW   = $clog2(PAGES);
  localparam int LW   = $clog2(PAGES + 1);
  localparam int OIW  = (ORDERS > 1) ? $clog2(ORDERS) : 1;
  localparam int CMPW = (LW > IDX_W) ? LW : IDX_W;
  localparam int PCW  = (LW > PCNT_W) ? LW : PCNT_W;
  localparam logic [LW-1:0] NIL = LW'(PAGES);

  // Control and working registers.
  state_e              state_q, state_d;
  state_e              ret_q, ret_d;
  state_e              fret_q, fret_d;
  logic                init_q, init_d;
  logic [LW-1:0]       i_q, i_d;
  logic [IW-1:0]       p_q, p_d;
  logic [IW-1:0]       b_q, b_d;
  logic [IW-1:0]       x_q, x_d;
  logic [LW-1:0]       h_q, h_d;
  logic [OQ_W-1:0]     ord_q, ord_d;
  logic [REQ_W-1:0]    req_q, req_d;
  logic [IDX_W-1:0]    res_block_q, res_block_d;
  status_e             res_status_q, res_status_d;
  logic                out_valid_q, out_valid_d;
  logic [IDX_W-1:0]    out_block_q, out_block_d;
  status_e             out_status_q, out_status_d;
  logic [PCNT_W-1:0]   page_count_q;
  logic [BASE_W-1:0]   base_page_q;
  logic [LW-1:0]       pool_pages_q, pool_pages_d;
  logic [BASE_W-1:0]   pool_base_q, pool_base_d;
  logic [LW-1:0]       list_head_q [ORDERS];
  logic [CNT_W-1:0]    free_count_q [ORDERS];

  // Memories and their ports.
  meta_t               meta_mem [PAGES];
  logic [LW-1:0]       next_mem [PAGES];
  logic [LW-1:0]       prev_mem [PAGES];
  meta_t               meta_rd_q;
  logic [LW-1:0]       next_rd_q;
  logic [LW-1:0]       prev_rd_q;
  logic [IW-1:0]       rd_addr;
  logic                meta_we;
  logic [IW-1:0]       meta_wa;
  meta_t               meta_wd;
  logic                next_we;
  logic [IW-1:0]       next_wa;
  logic [LW-1:0]       next_wd;
  logic                prev_we;
  logic [IW-1:0]       prev_wa;
  logic [LW-1:0]       prev_wd;

  // List table controls.
  logic                lists_clr;
  logic                head_we;
  logic [LW-1:0]       head_wd;
  logic                cnt_inc;
  logic                cnt_dec;

  // Buddy unit.
  logic                bud_load;
  logic [ORD_W-1:0]    bud_order;
  logic                bud_exists;
  logic [IW-1:0]       bud_idx;

  // Derived values.
  logic                in_acc;
  logic                idx_in_pool;
  logic [LW-1:0]       pc_sat;
  logic [OIW-1:0]      oi;
  logic                ord_ok;
  logic [LW-1:0]       head_cur;
  logic [CNT_W-1:0]    cnt_cur;
  logic [OQ_W-1:0]     ord_nxt;
  logic [OQ_W-1:0]     ord_dec;
  logic [IW-1:0]       lo_pg;
  logic [IW-1:0]       hi_pg;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign out_valid_o  = out_valid_q;
  assign block_page_o = out_block_q;
  assign status_o     = out_status_q;

  assign idx_in_pool = CMPW'(page_index_i) < CMPW'(pool_pages_q);
  assign pc_sat      = (PCW'(page_count_q) > PCW'(PAGES)) ? NIL : LW'(page_count_q);
  assign oi          = ord_q[OIW-1:0];
  assign ord_ok      = ord_q < OQ_W'(ORDERS);
  assign head_cur    = list_head_q[oi];
  assign cnt_cur     = free_count_q[oi];
  assign ord_nxt     = ord_q + 1'b1;
  assign ord_dec     = ord_q - 1'b1;
  assign lo_pg       = (b_q < p_q) ? b_q : p_q;
  assign hi_pg       = (b_q < p_q) ? p_q : b_q;

  bpa_buddy #(
    .PAGES (PAGES)
  ) u_buddy (
    .clk_i        (clk_i),
    .load_i       (bud_load),
    .page_i       (p_q),
    .order_i      (bud_order),
    .pool_base_i  (pool_base_q),
    .pool_pages_i (pool_pages_q),
    .exists_o     (bud_exists),
    .buddy_o      (bud_idx)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SWEEP: begin
        if (i_q == LW'(PAGES - 1)) state_d = init_q ? ST_INIT_FREE : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (op_i)
            OP_INIT:  state_d = ST_SWEEP;
            OP_FREE:  state_d = idx_in_pool ? ST_F_RD : ST_DONE;
            OP_ALLOC: state_d = ST_A_SCAN;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_INIT_FREE: state_d = (i_q < pool_pages_q) ? ST_F_RD : ST_DONE;
      ST_F_RD:      state_d = ST_F_CHK;
      ST_F_CHK:     state_d = meta_rd_q.used ? ST_PUSH1 : ST_DONE;
      ST_F_RM:      state_d = ST_RM_RD;
      ST_F_LOOP:    state_d = (ord_nxt < OQ_W'(ORDERS)) ? ST_F_BUD : ST_F_FIN;
      ST_F_BUD:     state_d = bud_exists ? ST_F_BMETA : ST_F_FIN;
      ST_F_BMETA: begin
        if (meta_rd_q.used || (meta_rd_q.order != ord_q[ORD_W-1:0])) state_d = ST_F_FIN;
        else state_d = ST_RM_RD;
      end
      ST_F_MRG1:    state_d = ST_F_MRG2;
      ST_F_MRG2:    state_d = ST_F_LOOP;
      ST_F_FIN:     state_d = ST_PUSH1;
      ST_A_SCAN: begin
        if (!ord_ok) state_d = ST_DONE;
        else if (cnt_cur == '0) state_d = ST_A_SCAN;
        else if (head_cur >= NIL) state_d = ST_DONE;
        else state_d = ST_RM_RD;
      end
      ST_A_LOOP:    state_d = (ord_q > OQ_W'(req_q)) ? ST_A_BUD : ST_DONE;
      ST_A_BUD:     state_d = bud_exists ? ST_PUSH1 : ST_A_LOOP;
      ST_PUSH1:     state_d = ord_ok ? ST_PUSH2 : ret_q;
      ST_PUSH2:     state_d = ret_q;
      ST_RM_RD:     state_d = ord_ok ? ST_RM_WR : ret_q;
      ST_RM_WR:     state_d = ret_q;
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // Datapath, memory and list controls per state.
  always_comb begin
    ret_d        = ret_q;
    fret_d       = fret_q;
    init_d       = init_q;
    i_d          = i_q;
    p_d          = p_q;
    b_d          = b_q;
    x_d          = x_q;
    h_d          = h_q;
    ord_d        = ord_q;
    req_d        = req_q;
    res_block_d  = res_block_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_block_d  = out_block_q;
    out_status_d = out_status_q;
    pool_pages_d = pool_pages_q;
    pool_base_d  = pool_base_q;
    rd_addr      = x_q;
    meta_we      = 1'b0;
    meta_wa      = p_q;
    meta_wd      = meta_rd_q;
    next_we      = 1'b0;
    next_wa      = x_q;
    next_wd      = NIL;
    prev_we      = 1'b0;
    prev_wa      = x_q;
    prev_wd      = NIL;
    lists_clr    = 1'b0;
    head_we      = 1'b0;
    head_wd      = NIL;
    cnt_inc      = 1'b0;
    cnt_dec      = 1'b0;
    bud_load     = 1'b0;
    bud_order    = ord_q[ORD_W-1:0];

    // The result register empties when the consumer takes it.
    if (!out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_SWEEP: begin
        meta_we       = 1'b1;
        meta_wa       = i_q[IW-1:0];
        meta_wd.used  = 1'b1;
        meta_wd.order = '0;
        i_d           = (i_q == LW'(PAGES - 1)) ? '0 : i_q + 1'b1;
      end
      ST_IDLE: begin
        if (in_acc) begin
          res_block_d  = '0;
          res_status_d = STAT_OK;
          unique case (op_i)
            OP_INIT: begin
              pool_pages_d = pc_sat;
              pool_base_d  = base_page_q;
              lists_clr    = 1'b1;
              i_d          = '0;
              init_d       = 1'b1;
            end
            OP_FREE: begin
              if (!idx_in_pool) res_status_d = STAT_RANGE;
              p_d    = IW'(page_index_i);
              fret_d = ST_DONE;
            end
            OP_ALLOC: begin
              ord_d = OQ_W'(req_order_i);
              req_d = req_order_i;
            end
            default: ;
          endcase
        end
      end
      ST_INIT_FREE: begin
        if (i_q < pool_pages_q) begin
          p_d    = i_q[IW-1:0];
          i_d    = i_q + 1'b1;
          fret_d = ST_INIT_FREE;
        end else begin
          init_d = 1'b0;
        end
      end
      ST_F_RD: rd_addr = p_q;
      ST_F_CHK: begin
        if (!meta_rd_q.used) begin
          res_status_d = STAT_NOTUSED;
        end else begin
          ord_d         = OQ_W'(meta_rd_q.order);
          meta_we       = 1'b1;
          meta_wa       = p_q;
          meta_wd.used  = 1'b0;
          meta_wd.order = meta_rd_q.order;
          x_d           = p_q;
          ret_d         = ST_F_RM;
        end
      end
      ST_F_RM: begin
        x_d   = p_q;
        ret_d = ST_F_LOOP;
      end
      ST_F_LOOP: begin
        bud_load  = 1'b1;
        bud_order = ord_q[ORD_W-1:0];
      end
      ST_F_BUD: begin
        b_d     = bud_idx;
        rd_addr = bud_idx;
      end
      ST_F_BMETA: begin
        x_d   = b_q;
        ret_d = ST_F_MRG1;
      end
      // The upper half gets marked used, the lower half becomes the merged block.
      ST_F_MRG1: begin
        meta_we       = 1'b1;
        meta_wa       = hi_pg;
        meta_wd.used  = 1'b1;
        meta_wd.order = ord_q[ORD_W-1:0];
      end
      ST_F_MRG2: begin
        meta_we       = 1'b1;
        meta_wa       = lo_pg;
        meta_wd.used  = 1'b0;
        meta_wd.order = ord_nxt[ORD_W-1:0];
        p_d           = lo_pg;
        ord_d         = ord_nxt;
      end
      ST_F_FIN: begin
        x_d   = p_q;
        ret_d = fret_q;
      end
      ST_A_SCAN: begin
        if (!ord_ok) begin
          res_status_d = STAT_NOMEM;
        end else if (cnt_cur == '0) begin
          ord_d = ord_nxt;
        end else if (head_cur >= NIL) begin
          res_status_d = STAT_NOMEM;
        end else begin
          p_d   = head_cur[IW-1:0];
          x_d   = head_cur[IW-1:0];
          ret_d = ST_A_LOOP;
        end
      end
      // Split down to the requested order, one level per pass.
      ST_A_LOOP: begin
        if (ord_q > OQ_W'(req_q)) begin
          ord_d     = ord_dec;
          bud_load  = 1'b1;
          bud_order = ord_dec[ORD_W-1:0];
        end else begin
          meta_we       = 1'b1;
          meta_wa       = p_q;
          meta_wd.used  = 1'b1;
          meta_wd.order = req_q;
          res_block_d   = IDX_W'(p_q);
        end
      end
      ST_A_BUD: begin
        if (bud_exists) begin
          meta_we       = 1'b1;
          meta_wa       = bud_idx;
          meta_wd.used  = 1'b0;
          meta_wd.order = ord_q[ORD_W-1:0];
          x_d           = bud_idx;
          ret_d         = ST_A_LOOP;
        end
      end
      // List push: link in at the head, then fix the old head's back link.
      ST_PUSH1: begin
        if (ord_ok) begin
          next_we = 1'b1;
          next_wa = x_q;
          next_wd = head_cur;
          prev_we = 1'b1;
          prev_wa = x_q;
          prev_wd = NIL;
          head_we = 1'b1;
          head_wd = LW'(x_q);
          cnt_inc = 1'b1;
          h_d     = head_cur;
        end
      end
      ST_PUSH2: begin
        if (h_q < NIL) begin
          prev_we = 1'b1;
          prev_wa = h_q[IW-1:0];
          prev_wd = LW'(x_q);
        end
      end
      ST_RM_RD: rd_addr = x_q;
      // List removal: bypass the entry in both directions.
      ST_RM_WR: begin
        if (prev_rd_q < NIL) begin
          next_we = 1'b1;
          next_wa = prev_rd_q[IW-1:0];
          next_wd = next_rd_q;
        end else begin
          head_we = 1'b1;
          head_wd = (next_rd_q < NIL) ? next_rd_q : NIL;
        end
        if (next_rd_q < NIL) begin
          prev_we = 1'b1;
          prev_wa = next_rd_q[IW-1:0];
          prev_wd = prev_rd_q;
        end
        cnt_dec = 1'b1;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_block_d  = res_block_q;
          out_status_d = res_status_q;
        end
      end
      default: ;
    endcase
  end

  // Page memories: one write and one registered read each.
  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    meta_rd_q <= meta_mem[rd_addr];
    next_rd_q <= next_mem[rd_addr];
    prev_rd_q <= prev_mem[rd_addr];
  end

  // Per-order list heads and free counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ORDERS; k++) begin
        list_head_q[k]  <= NIL;
        free_count_q[k] <= '0;
      end
    end else if (lists_clr) begin
      for (int k = 0; k < ORDERS; k++) begin
        list_head_q[k]  <= NIL;
        free_count_q[k] <= '0;
      end
    end else begin
      if (head_we) list_head_q[oi] <= head_wd;
      if (cnt_inc) free_count_q[oi] <= cnt_cur + 1'b1;
      else if (cnt_dec) free_count_q[oi] <= cnt_cur - 1'b1;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_count_q <= '0;
      base_page_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PAGE_COUNT: page_count_q <= cfg_data_i[PCNT_W-1:0];
        REG_BASE_PAGE:  base_page_q  <= cfg_data_i[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      ret_q        <= ST_IDLE;
      fret_q       <= ST_IDLE;
      init_q       <= 1'b0;
      i_q          <= '0;
      p_q          <= '0;
      b_q          <= '0;
      x_q          <= '0;
      h_q          <= '0;
      ord_q        <= '0;
      req_q        <= '0;
      res_block_q  <= '0;
      res_status_q <= STAT_OK;
      out_valid_q  <= 1'b0;
      out_block_q  <= '0;
      out_status_q <= STAT_OK;
      pool_pages_q <= '0;
      pool_base_q  <= '0;
    end else begin
      state_q      <= state_d;
      ret_q        <= ret_d;
      fret_q       <= fret_d;
      init_q       <= init_d;
      i_q          <= i_d;
      p_q          <= p_d;
      b_q          <= b_d;
      x_q          <= x_d;
      h_q          <= h_d;
      ord_q        <= ord_d;
      req_q        <= req_d;
      res_block_q  <= res_block_d;
      res_status_q <= res_status_d;
      out_valid_q  <= out_valid_d;
      out_block_q  <= out_block_d;
      out_status_q <= out_status_d;
      pool_pages_q <= pool_pages_d;
      pool_base_q  <= pool_base_d;
    end
  end

`ifndef SYNTHESIS
  a_sweep_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> in_stall_o)
    else $error("transaction taken during memory sweep");

  a_error_has_zero_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STAT_OK)) |-> (block_page_o == '0))
    else $error("error result carries a block index");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside the done state");
`endif

endmodule

FILE: dv/tb_buddy_page_allocator.sv
// Self-checking testbench for buddy_page_allocator: random and directed allocate,
// free and init transactions checked against a built-in buddy allocator predictor.
// Depends on bpa_pkg and the buddy_page_allocator RTL.
module tb_buddy_page_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import bpa_pkg::*;

  localparam int NPAGES  = 4096;
  localparam int NORDERS = 11;
  localparam int NONE    = NPAGES;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Tracks allocator state and the queue of results still owed by the block.
  class bpa_scoreboard;
    bit               used_m[NPAGES];
    logic [ORD_W-1:0] ord_m[NPAGES];
    int               nxt_m[NPAGES];
    int               prv_m[NPAGES];
    int               head_m[NORDERS];
    logic [CNT_W-1:0] cnt_m[NORDERS];
    logic [PCNT_W-1:0] pcount_r;
    logic [BASE_W-1:0] base_r;
    int               pool_n;
    logic [63:0]      pool_b;
    logic [IDX_W-1:0] want_block[$];
    status_e          want_status[$];
    int               live[$];
    int               mismatches;
    int               n_alloc_ok, n_free_ok, n_nomem, n_notused, n_range, n_init;

    function new();
      foreach (used_m[i]) begin
        used_m[i] = 1'b1;
        ord_m[i] = '0;
        nxt_m[i] = 0;
        prv_m[i] = 0;
      end
      foreach (head_m[i]) begin
        head_m[i] = NONE;
        cnt_m[i] = '0;
      end
      pcount_r = '0;
      base_r = '0;
      pool_n = 0;
      pool_b = '0;
    endfunction

    function void set_reg(reg_e r, logic [CFG_W-1:0] v);
      if (r == REG_PAGE_COUNT) pcount_r = v[PCNT_W-1:0];
      else base_r = v[BASE_W-1:0];
    endfunction

    function int pending();
      return want_status.size();
    endfunction

    function void push_free(int p, int o);
      int h;
      h = head_m[o];
      nxt_m[p] = h;
      prv_m[p] = NONE;
      if (h < NPAGES) prv_m[h] = p;
      head_m[o] = p;
      cnt_m[o] = cnt_m[o] + 1'b1;
    endfunction

    function void unlink(int p, int o);
      int n;
      int pv;
      n = nxt_m[p];
      pv = prv_m[p];
      if (pv < NPAGES) nxt_m[pv] = n;
      else head_m[o] = (n < NPAGES) ? n : NONE;
      if (n < NPAGES) prv_m[n] = pv;
      cnt_m[o] = cnt_m[o] - 1'b1;
    endfunction

    // Buddy by XOR on the absolute page number; absent if it falls outside the pool.
    function bit buddy_of(int p, int o, output int b);
      logic [63:0] a;
      a = (pool_b + 64'(p)) ^ (64'd1 << o);
      b = 0;
      if (a < pool_b) return 1'b0;
      if (a - pool_b >= 64'(pool_n)) return 1'b0;
      b = int'(a - pool_b);
      return 1'b1;
    endfunction

    function void release_block(int p_in);
      int p;
      int o;
      int b;
      p = p_in;
      o = int'(ord_m[p]);
      used_m[p] = 1'b0;
      push_free(p, o);
      unlink(p, o);
      while (o + 1 < NORDERS) begin
        if (!buddy_of(p, o, b)) break;
        if (used_m[b] || int'(ord_m[b]) != o) break;
        unlink(b, o);
        used_m[(b < p) ? p : b] = 1'b1;
        p = (b < p) ? b : p;
        o++;
        ord_m[p] = ORD_W'(o);
      end
      push_free(p, o);
    endfunction

    // Works out the result of one accepted transaction.
    function void note(logic [OP_W-1:0] op, logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx);
      int blk;
      status_e st;
      int o;
      int p;
      int b;
      blk = 0;
      st = STAT_OK;
      case (op)
        OP_INIT: begin
          pool_n = (pcount_r > NPAGES) ? NPAGES : int'(pcount_r);
          pool_b = 64'(base_r);
          foreach (used_m[i]) begin
            used_m[i] = 1'b1;
            ord_m[i] = '0;
          end
          foreach (head_m[i]) begin
            head_m[i] = NONE;
            cnt_m[i] = '0;
          end
          for (int i = 0; i < pool_n; i++) release_block(i);
          live.delete();
          n_init++;
        end
        OP_FREE: begin
          if (idx >= pool_n) st = STAT_RANGE;
          else if (!used_m[idx]) st = STAT_NOTUSED;
          else begin
            release_block(int'(idx));
            foreach (live[i]) if (live[i] == idx) begin
              live.delete(i);
              break;
            end
            n_free_ok++;
          end
        end
        OP_ALLOC: begin
          o = int'(req);
          while (o < NORDERS && cnt_m[o] == 0) o++;
          if (o >= NORDERS || head_m[o] >= NPAGES) st = STAT_NOMEM;
          else begin
            p = head_m[o];
            unlink(p, o);
            used_m[p] = 1'b0;
            while (o > req) begin
              o--;
              if (buddy_of(p, o, b)) begin
                used_m[b] = 1'b0;
                ord_m[b] = ORD_W'(o);
                push_free(b, o);
              end
            end
            ord_m[p] = req;
            used_m[p] = 1'b1;
            blk = p;
            live.push_back(p);
            n_alloc_ok++;
          end
        end
        default: ;
      endcase
      if (st == STAT_NOMEM) n_nomem++;
      if (st == STAT_NOTUSED) n_notused++;
      if (st == STAT_RANGE) n_range++;
      want_block.push_back(IDX_W'(blk));
      want_status.push_back(st);
    endfunction

    function void check(logic [IDX_W-1:0] blk, logic [STAT_W-1:0] st);
      logic [IDX_W-1:0] eb;
      status_e es;
      if (want_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: block_page=%0d status=%0d", blk, st);
        return;
      end
      eb = want_block.pop_front();
      es = want_status.pop_front();
      if (eb !== blk || es !== st) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected block_page=%0d status=%0d, got block_page=%0d status=%0d",
                   eb, es, blk, st);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic                cfg_idx = 1'b0;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     op = '0;
  logic [REQ_W-1:0]    req_order = '0;
  logic [IDX_W-1:0]    page_index = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [IDX_W-1:0]    block_page;
  logic [STAT_W-1:0]   status;

  bpa_scoreboard sb = new();
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  buddy_page_allocator dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .op_i(op), .req_order_i(req_order), .page_index_i(page_index),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .block_page_o(block_page), .status_o(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold == 0) begin
        hold = 300;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 27);
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check(block_page, status);
  end

  initial begin
    #30ms;
    $display("== FAIL ==");
    $finish;
  end

  task automatic write_reg(reg_e r, logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= r;
    cfg_data <= v;
    sb.set_reg(r, v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offers one transaction and returns at the edge that accepts it.
  task automatic send(logic [OP_W-1:0] o, logic [REQ_W-1:0] rq, logic [IDX_W-1:0] ix);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    req_order <= rq;
    page_index <= ix;
    do @(posedge clk); while (in_stall);
    sb.note(o, rq, ix);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One pool setting: configure, init, then a mix of mostly well-formed traffic.
  task automatic run_pool(logic [PCNT_W-1:0] pc, logic [BASE_W-1:0] base, int n);
    int r;
    write_reg(REG_PAGE_COUNT, CFG_W'(pc));
    write_reg(REG_BASE_PAGE, CFG_W'(base));
    send(OP_INIT, 4'($urandom), 12'($urandom));
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 45 || (r < 85 && sb.live.size() == 0))
        send(OP_ALLOC, ($urandom_range(99) < 85) ? 4'($urandom_range(3)) : 4'($urandom),
             12'($urandom));
      else if (r < 85)
        send(OP_FREE, 4'($urandom), 12'(sb.live[$urandom_range(sb.live.size() - 1)]));
      else if (r < 93)
        send(OP_FREE, 4'($urandom), 12'($urandom));
      else if (r < 98)
        send(OP_FREE, 4'($urandom), 12'($urandom_range(pc + 2)));
      else if (r == 98 && pc <= 600)
        send(OP_INIT, 4'($urandom), 12'($urandom));
      else
        send(OP_UNUSED, 4'($urandom), 12'($urandom));
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty pool, unused op, saturated size, extreme orders and indexes.
    send(OP_FREE, 4'd0, 12'd5);
    send(OP_ALLOC, 4'd0, 12'd0);
    send(OP_UNUSED, 4'd15, 12'd4095);
    drain();
    write_reg(REG_PAGE_COUNT, CFG_W'(13'h1FFF));
    write_reg(REG_BASE_PAGE, '0);
    send(OP_INIT, 4'd0, 12'd0);
    send(OP_ALLOC, 4'd15, 12'd0);
    send(OP_ALLOC, 4'd11, 12'd0);
    send(OP_ALLOC, 4'd10, 12'd0);
    send(OP_ALLOC, 4'd0, 12'd0);
    send(OP_ALLOC, 4'd3, 12'd0);
    send(OP_ALLOC, 4'd10, 12'd0);
    send(OP_ALLOC, 4'd10, 12'd0);
    send(OP_ALLOC, 4'd10, 12'd0);
    send(OP_FREE, 4'd0, 12'(sb.live[0]));
    send(OP_FREE, 4'd0, 12'(sb.live[0]));
    send(OP_FREE, 4'd0, 12'd4095);
    send(OP_FREE, 4'd0, 12'd4095);
    send(OP_FREE, 4'd0, 12'd1);
    send(OP_FREE, 4'd0, 12'd0);
    send(OP_ALLOC, 4'd0, 12'd4095);
    drain();

    run_pool(13'd4096, 40'hFF_FFFF_FFFF, 140);
    run_pool(13'd0, 40'($urandom), 40);
    run_pool(13'd1, '0, 40);
    run_pool(13'd37, 40'd5, 95);
    run_pool(13'd256, '0, 100);
    run_pool(13'd100, {8'($urandom), 32'($urandom)}, 100);
    run_pool(13'd200, 40'h10_0000_0003, 100);
    run_pool(13'd513, {8'($urandom), 32'($urandom)}, 100);
    run_pool(13'd64, 40'hFF_FFFF_FFFF, 100);
    calm = 1'b1;
    run_pool(13'd150, {8'($urandom), 32'($urandom)}, 100);
    calm = 1'b0;
    hold_req = 1'b1;
    run_pool(13'd120, '0, 100);

    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (64) @(posedge clk);
    $display("Covered %0d inits, %0d good allocations, %0d good frees.",
             sb.n_init, sb.n_alloc_ok, sb.n_free_ok);
    $display("Errors flagged: %0d out of memory, %0d not allocated, %0d out of pool.",
             sb.n_nomem, sb.n_notused, sb.n_range);
    if (sb.mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
